// ===== sv/rud_pkg.sv =====
// shared types and constants for the ranked unary decoder
// no dependencies; imported by every rud module and by rank_unary_decoder
package rud_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W         = 9;
    localparam int RUN_W           = 8;
    localparam int BYTE_W          = 8;
    localparam int BIT_CNT_W       = 3;

    localparam logic [RUN_W-1:0]     RUN_MAX    = 8'hFF;
    localparam logic [BIT_CNT_W-1:0] BIT_FIRST  = 3'd7;
    localparam logic [COUNT_W-1:0]   COUNT_FULL = 9'd256;

    typedef struct packed {
        logic              start_req;
        logic [BYTE_W-1:0] in_byte;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] symbol;
        logic              rank_error;
        logic              last;
    } result_t;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_LOAD  = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OP_COUNT = 2'd0,
        OP_LOAD  = 2'd1,
        OP_DATA  = 2'd2
    } op_t;

    // one classified byte on its way from front to back
    typedef struct packed {
        op_t                op;
        logic [BYTE_W-1:0]  value;
        logic [COUNT_W-1:0] arg;    // table index for loads, loaded count for count bytes
    } entry_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SCAN = 1'b1
    } scan_state_t;

endpackage

// ===== sv/rud_front.sv =====
// front end: accepts coded bytes, tracks the header phase and classifies each byte
// depends on rud_pkg
module rud_front
    import rud_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_ready,
    input  item_t  item,
    output logic   push_valid,
    input  logic   push_ready,
    output entry_t push_entry
);

    localparam logic [COUNT_W-1:0] DEPTH_N = COUNT_W'(TABLE_DEPTH);

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] load_idx_reg, load_idx_next;

    logic               accept;
    logic               take_count;
    logic [COUNT_W-1:0] decoded_count;
    logic [COUNT_W-1:0] loaded_count;
    logic [COUNT_W-1:0] idx_inc;

    assign item_ready    = push_ready;
    assign accept        = item_valid && push_ready;
    assign take_count    = item.start_req || (phase_reg != PH_LOAD && phase_reg != PH_DATA);
    assign decoded_count = (item.in_byte == '0) ? COUNT_FULL : {1'b0, item.in_byte};
    assign loaded_count  = (decoded_count > DEPTH_N) ? DEPTH_N : decoded_count;
    assign idx_inc       = load_idx_reg + 1'b1;

    // classification toward the queue
    always_comb
    begin
        push_valid       = 1'b0;
        push_entry.op    = OP_DATA;
        push_entry.value = item.in_byte;
        push_entry.arg   = load_idx_reg;
        if (take_count)
        begin
            push_valid     = item_valid;
            push_entry.op  = OP_COUNT;
            push_entry.arg = loaded_count;
        end
        else
        begin
            case (phase_reg)
                PH_LOAD:
                begin
                    // header symbols past the table are consumed but not stored
                    push_valid    = item_valid && (load_idx_reg < DEPTH_N);
                    push_entry.op = OP_LOAD;
                end
                PH_DATA:
                begin
                    push_valid    = item_valid;
                    push_entry.op = OP_DATA;
                end
                default:
                begin
                    push_valid = 1'b0;
                end
            endcase
        end
    end

    // header phase tracking
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        load_idx_next = load_idx_reg;
        if (accept)
        begin
            if (take_count)
            begin
                phase_next    = PH_LOAD;
                count_next    = decoded_count;
                load_idx_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_LOAD:
                    begin
                        load_idx_next = idx_inc;
                        if (idx_inc >= count_reg)
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COUNT;
            count_reg    <= '0;
            load_idx_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            load_idx_reg <= load_idx_next;
        end
    end

    // while loading, the index never reaches the declared count
    a_load_idx_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LOAD |-> load_idx_reg < count_reg)
        else $error("load index reached count while loading");

    // a start byte always opens table loading
    a_start_opens_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.start_req |=> phase_reg == PH_LOAD)
        else $error("start transaction did not enter load phase");

    // a data byte is queued only in the data phase
    a_data_only_in_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_entry.op == OP_DATA |-> phase_reg == PH_DATA)
        else $error("data byte queued outside data phase");

endmodule

// ===== sv/rud_queue.sv =====
// short queue of classified bytes between front and back
// depends on rud_pkg
module rud_queue
    import rud_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_entry
);

    localparam logic [QPTR_W:0] FULL_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    entry_t            entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("queue fill beyond depth");

    a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue fill did not grow on push");

    a_ptr_gap_matches_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != FULL_CNT |-> (wr_ptr_reg - rd_ptr_reg) == cnt_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with fill");

endmodule

// ===== sv/rud_back.sv =====
// back end: writes the rank table, scans data bytes and emits symbols, one bit per
// cycle unless a zero bit waits on a held output; depends on rud_pkg
module rud_back
    import rud_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  entry_t  pop_entry,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [BYTE_W-1:0] table_mem [TABLE_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    scan_state_t          state_reg, state_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [BIT_CNT_W-1:0] bits_reg, bits_next;
    logic [RUN_W-1:0]     run_reg, run_next;
    logic [COUNT_W-1:0]   loaded_reg, loaded_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_err_reg, out_err_next;
    logic                 out_last_reg, out_last_next;

    logic              cur_bit;
    logic              slot_free;
    logic              emit;
    logic              advance;
    logic              done_now;
    logic              take;
    logic              range_err;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    assign cur_bit   = shift_reg[BYTE_W-1];
    assign slot_free = !out_valid_reg || result_ready;
    assign range_err = {1'b0, run_reg} >= loaded_reg;
    assign rd_addr   = run_reg[ADDR_W-1:0];
    assign wr_addr   = pop_entry.arg[ADDR_W-1:0];

    // scan control outputs
    always_comb
    begin
        emit      = 1'b0;
        advance   = 1'b0;
        pop_ready = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
            end
            BK_SCAN:
            begin
                emit      = !cur_bit && slot_free;
                advance   = cur_bit || slot_free;
                pop_ready = advance && (bits_reg == '0);
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    assign done_now = advance && (bits_reg == '0);
    assign take     = pop_valid && pop_ready;
    assign wr_en    = take && (pop_entry.op == OP_LOAD);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (take && pop_entry.op == OP_DATA)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (done_now)
                begin
                    state_next = (take && pop_entry.op == OP_DATA) ? BK_SCAN : BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        shift_next     = shift_reg;
        bits_next      = bits_reg;
        run_next       = run_reg;
        loaded_next    = loaded_reg;
        out_valid_next = result_ready ? 1'b0 : out_valid_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;

        if (advance)
        begin
            // ones shifted in make the remaining-bits check a plain and-reduce
            shift_next = {shift_reg[BYTE_W-2:0], 1'b1};
            bits_next  = bits_reg - 1'b1;
            if (cur_bit)
            begin
                if (run_reg != RUN_MAX)
                begin
                    run_next = run_reg + 1'b1;
                end
            end
            else
            begin
                run_next = '0;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_err_next   = range_err;
            out_last_next  = &shift_reg[BYTE_W-2:0];
        end

        if (take)
        begin
            case (pop_entry.op)
                OP_COUNT:
                begin
                    loaded_next = pop_entry.arg;
                    run_next    = '0;
                end
                OP_DATA:
                begin
                    shift_next = pop_entry.value;
                    bits_next  = BIT_FIRST;
                end
                default:
                begin
                    loaded_next = loaded_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            shift_reg     <= '0;
            bits_reg      <= '0;
            run_reg       <= '0;
            loaded_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_err_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            bits_reg      <= bits_next;
            run_reg       <= run_next;
            loaded_reg    <= loaded_next;
            out_valid_reg <= out_valid_next;
            out_err_reg   <= out_err_next;
            out_last_reg  <= out_last_next;
        end
    end

    // rank table, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= pop_entry.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign result_valid      = out_valid_reg;
    assign result.symbol     = out_err_reg ? '0 : rd_data_reg;
    assign result.rank_error = out_err_reg;
    assign result.last       = out_last_reg;

    // a new entry is taken mid-scan only on the final bit
    a_pop_at_byte_end: assert property (@(posedge clk) disable iff (!rst_n)
        take && state_reg == BK_SCAN |-> bits_reg == '0)
        else $error("queue popped before scan finished");

    // run counter saturates
    a_run_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cur_bit && run_reg == RUN_MAX && !take |=> run_reg == RUN_MAX)
        else $error("run counter wrapped");

    // every zero bit shows up as a result in the next cycle
    a_emit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> result_valid && result.last == $past(&shift_reg[BYTE_W-2:0]))
        else $error("emitted result missing at output");

endmodule

// ===== sv/rank_unary_decoder.sv =====
// top level of the frequency-ranked unary code decoder
// depends on rud_pkg, rud_front, rud_queue, rud_back
//
// usage
//   item channel (item_valid/item_ready/item): one coded byte per transaction,
//   item.start_req marks the count byte of a new stream. the count byte (0 = 256)
//   is followed by that many symbols in rank order, then the coded data bytes
//   result channel (result_valid/result_ready/result): one decoded symbol per
//   transaction, data bits scanned msb first; result.last flags the final symbol
//   of a data byte, result.rank_error flags a run past the loaded table (symbol 0)
//   header bytes and data bytes with no zero bit give no result
// timing
//   front takes one byte per cycle while the four-entry queue has room
//   back takes each header byte from the queue without a scan, and scans each
//   data byte one bit per cycle while no zero bit waits on a held output,
//   with one table read per zero bit; the next entry is taken with the final bit;
//   a result passes the queue, the shift register and the output register
// reset
//   rst_n clears phase to header count, the run and loaded count, and the queue
//   the rank table is not cleared; symbols only come from header-written entries
// stalls
//   result_ready low holds the output register; the scan pauses on zero bits,
//   the queue fills, then item_ready drops
module rank_unary_decoder
    import rud_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // front to queue
    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;

    // queue to back
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_entry;

    // header tracking and byte classification
    rud_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // decouples byte intake from the bit scan
    rud_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // table writes, bit scan, table lookup and output register
    rud_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for rank_unary_decoder: directed table, saturated run, random streams
// depends on rud_pkg and the rank_unary_decoder rtl; every result is predicted in this file
module tb_top;
    import rud_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int TAB_AW       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_WAIT   = 40;
    localparam int MAX_REPORTS  = 40;
    localparam int RANDOM_ITEMS = 40;

    // one directed transaction; typed rows carry their results inline
    typedef struct {
        item_t             it;
        bit                typed;
        int                n_res;
        logic [BYTE_W-1:0] sym;
        logic              err;
    } row_t;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // decoder state as predicted
    phase_t             dec_phase;
    logic [COUNT_W-1:0] dec_count;
    logic [COUNT_W-1:0] dec_load_idx;
    logic [RUN_W-1:0]   dec_run;
    logic [BYTE_W-1:0]  rank_tab [DEPTH];
    result_t            decoded [8];

    result_t     pending_symbols [$];
    row_t        directed_rows [$];
    int          fail_count    = 0;
    int unsigned cycle_count   = 0;
    int          src_free      = 0;
    int          items_sent    = 0;
    bit          long_hold_req = 1'b0;

    rank_unary_decoder #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        logic [31:0] r;
        r = $urandom();
        return r[BYTE_W-1:0];
    endfunction

    function automatic item_t make_item(logic start, logic [BYTE_W-1:0] value);
        item_t it;
        it.start_req = start;
        it.in_byte   = value;
        return it;
    endfunction

    // advances the predicted state by one byte, fills decoded[], returns the symbol count
    function automatic int rank_decode(item_t it);
        int                 n;
        int                 b;
        logic [COUNT_W-1:0] loaded;
        n = 0;
        if (it.start_req || (dec_phase != PH_LOAD && dec_phase != PH_DATA))
        begin
            // count byte, 0 stands for a full table
            dec_count    = (it.in_byte == '0) ? COUNT_FULL : {1'b0, it.in_byte};
            dec_load_idx = '0;
            dec_run      = '0;
            dec_phase    = PH_LOAD;
        end
        else if (dec_phase == PH_LOAD)
        begin
            if (dec_load_idx < DEPTH)
                rank_tab[dec_load_idx[TAB_AW-1:0]] = it.in_byte;
            dec_load_idx = dec_load_idx + 1'b1;
            if (dec_load_idx >= dec_count)
                dec_phase = PH_DATA;
        end
        else
        begin
            loaded = dec_count;
            if (loaded > DEPTH)
                loaded = COUNT_W'(DEPTH);
            for (b = BYTE_W - 1; b >= 0; b--)
            begin
                if (it.in_byte[b])
                begin
                    if (dec_run != RUN_MAX)
                        dec_run = dec_run + 1'b1;
                end
                else
                begin
                    decoded[n].symbol     = (dec_run < loaded) ? rank_tab[dec_run] : '0;
                    decoded[n].rank_error = (dec_run >= loaded);
                    decoded[n].last       = 1'b0;
                    dec_run = '0;
                    n++;
                end
            end
            if (n > 0)
                decoded[n-1].last = 1'b1;
        end
        return n;
    endfunction

    function automatic void add_row(bit start, logic [BYTE_W-1:0] value, bit typed,
                                    int n_res, logic [BYTE_W-1:0] sym, logic err);
        row_t r;
        r.it    = make_item(start, value);
        r.typed = typed;
        r.n_res = n_res;
        r.sym   = sym;
        r.err   = err;
        directed_rows.push_back(r);
    endfunction

    // returns in the time step at which the transaction is accepted
    task automatic offer_item(input item_t it);
        int gap;
        int pick;
        gap = 0;
        if (src_free > 0)
            src_free--;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 60 && pick < 90)
                gap = gap_len();
            else if (pick >= 90)
                src_free = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
    endtask

    task automatic feed(input item_t it);
        int n;
        int k;
        offer_item(it);
        n = rank_decode(it);
        for (k = 0; k < n; k++)
            pending_symbols.push_back(decoded[k]);
    endtask

    // called right after an acceptance, so valid drops in that same step
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_symbols.size() != 0);
    endtask

    // header of random size, then a well-formed code of random ranks with some noise
    task automatic random_stream();
        int                count;
        int                n_ranks;
        int                rank;
        int                i;
        int                pick;
        bit                code_bits [$];
        logic [BYTE_W-1:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            count = $urandom_range(1, 6);
        else if (pick < 95)
            count = $urandom_range(7, 16);
        else
            count = $urandom_range(17, 32);
        if ($urandom_range(0, 9) == 0)
            wait_drained();
        feed(make_item(1'b1, count[BYTE_W-1:0]));
        for (i = 0; i < count; i++)
        begin
            // header cut short: the next stream restarts mid-load
            if ($urandom_range(0, 99) < 3)
                return;
            feed(make_item(1'b0, rand_byte()));
        end
        n_ranks = $urandom_range(1, 16);
        for (i = 0; i < n_ranks; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                rank = count + $urandom_range(0, 4);
            else
                rank = $urandom_range(0, count - 1);
            repeat (rank) code_bits.push_back(1'b1);
            code_bits.push_back(1'b0);
        end
        // padding ones up to a byte boundary
        while (code_bits.size() % BYTE_W != 0)
            code_bits.push_back(1'b1);
        while (code_bits.size() > 0)
        begin
            for (i = 0; i < BYTE_W; i++)
                value = {value[BYTE_W-2:0], code_bits.pop_front()};
            if ($urandom_range(0, 99) < 8)
                value = rand_byte();
            feed(make_item(1'b0, value));
        end
    endtask

    initial
    begin : stimulus
        row_t    r;
        result_t t;
        int      k;
        int      goal;

        dec_phase    = PH_COUNT;
        dec_count    = '0;
        dec_load_idx = '0;
        dec_run      = '0;

        // count byte right after reset without start_req, three ranks
        add_row(1'b0, 8'h03, 1'b1, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'hAA, 1'b1, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'h55, 1'b1, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'hFF, 1'b1, 0, 8'h00, 1'b0);
        // all zeros: eight times rank 0
        add_row(1'b0, 8'h00, 1'b1, 8, 8'hAA, 1'b0);
        add_row(1'b0, 8'h80, 1'b0, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'h40, 1'b0, 0, 8'h00, 1'b0);
        // all ones emit nothing, the run carries into the next byte
        add_row(1'b0, 8'hFF, 1'b1, 0, 8'h00, 1'b0);
        // run past the loaded ranks
        add_row(1'b0, 8'h7F, 1'b1, 1, 8'h00, 1'b1);
        add_row(1'b0, 8'h3F, 1'b0, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'hDF, 1'b0, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'h01, 1'b0, 0, 8'h00, 1'b0);
        // new stream in the data phase, then a restart in the middle of the header
        add_row(1'b1, 8'h02, 1'b1, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'h11, 1'b1, 0, 8'h00, 1'b0);
        add_row(1'b1, 8'h02, 1'b1, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'h22, 1'b1, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'h33, 1'b1, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'h55, 1'b0, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'hAA, 1'b0, 0, 8'h00, 1'b0);
        // single rank table holding symbol 0
        add_row(1'b1, 8'h01, 1'b1, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'h00, 1'b1, 0, 8'h00, 1'b0);
        add_row(1'b0, 8'h3F, 1'b1, 2, 8'h00, 1'b0);
        add_row(1'b0, 8'h7E, 1'b1, 2, 8'h00, 1'b1);
        // largest explicit count, left unfinished
        add_row(1'b1, 8'hFF, 1'b1, 0, 8'h00, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (!r.typed)
                feed(r.it);
            else
            begin
                offer_item(r.it);
                void'(rank_decode(r.it));
                for (k = 0; k < r.n_res; k++)
                begin
                    t.symbol     = r.sym;
                    t.rank_error = r.err;
                    t.last       = (k == r.n_res - 1);
                    pending_symbols.push_back(t);
                end
            end
        end

        // sender pause, then a zero count byte: 256 ranks, so zero bytes stay header
        wait_drained();
        feed(make_item(1'b1, 8'h00));
        for (k = 0; k < 4; k++)
            feed(make_item(1'b0, 8'h00));
        // two ranks, then a run that saturates and lands past the table
        feed(make_item(1'b1, 8'h02));
        feed(make_item(1'b0, rand_byte()));
        feed(make_item(1'b0, rand_byte()));
        for (k = 0; k < 32; k++)
            feed(make_item(1'b0, 8'hFF));
        feed(make_item(1'b0, 8'h00));
        feed(make_item(1'b0, 8'hFE));

        // receiver holds off while streams keep coming
        long_hold_req = 1'b1;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
            random_stream();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side backpressure
    initial
    begin : result_pacing
        int hold_left;
        int free_left;
        int pick;
        hold_left = 0;
        free_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (free_left > 0)
                    free_left--;
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 20)
                        hold_left = gap_len();
                    else if (pick < 25)
                        free_left = $urandom_range(20, 80);
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_symbols.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected transaction, expected none, actual %02h/%b/%b",
                             $time, result.symbol, result.rank_error, result.last);
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (result.symbol !== want.symbol || result.rank_error !== want.rank_error
                    || result.last !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: mismatch, expected %02h/%b/%b, actual %02h/%b/%b",
                                 $time, want.symbol, want.rank_error, want.last,
                                 result.symbol, result.rank_error, result.last);
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rud_pkg.sv
sv/rud_front.sv
sv/rud_queue.sv
sv/rud_back.sv
sv/rank_unary_decoder.sv
tb/sv/tb_top.sv
